FILE: design/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the deadline timer table: item layouts,
// channel count, codes for operations and result kinds.
// ----------------------------------------------------------------------------
package dtt_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);

	localparam logic OP_SUBMIT   = 1'b0;
	localparam logic OP_TICK     = 1'b1;
	localparam logic KIND_DONE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic signed [31:0] WAIT_NONE = -32'sd1;

	typedef struct packed {
		logic        op;
		logic [3:0]  channel;
		logic [31:0] deadline;
		logic [31:0] payload;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         done_channel;
		logic [31:0]        reply;
		logic signed [31:0] wait_time;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic        fire;
		logic [31:0] remain;
	} eval_t;

endpackage

FILE: design/dtt_eval.sv
// ----------------------------------------------------------------------------
// dtt_eval
// Per-entry check: expired test on the wrapped distance now - deadline, and
// the remaining time deadline - now clamped at zero.
// ----------------------------------------------------------------------------
module dtt_eval import dtt_pkg::*; (
	input  logic [31:0] now,
	input  logic [31:0] deadline,
	output eval_t       result
);

	logic [31:0] since;
	logic [31:0] until_dl;

	assign since    = now - deadline;
	assign until_dl = deadline - now;

	always_comb begin
		result.fire   = !since[31];
		// half-range distance reads negative and clamps to zero
		result.remain = until_dl[31] ? 32'd0 : until_dl;
	end

endmodule

FILE: design/deadline_timer_table_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// Channel table of pending deadlines with in-order expiry scan on each tick.
// ----------------------------------------------------------------------------
// A submit item arms one channel and does not block the input; it produces
// no result. A tick item scans the channel memory one entry per cycle, while
// the result side keeps up, through its single read port, emitting one
// completion item per expired pending channel and then a report item with the
// earliest remaining wait (or -1 when nothing is pending). After a tick is
// accepted the input stays blocked for the whole scan, also while the result
// side holds back a completion or the report; no new item is taken until the
// report has been loaded into the output register.
module deadline_timer_table_core import dtt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	entry_t            mem_q [CHANNELS];
	entry_t            rd_s1;
	logic [CHANNELS-1:0] pend_q;
	logic              scan_q;
	logic [CNT_W-1:0]  idx_q;
	logic              v_s1;
	logic [CH_W-1:0]   idx_s1;
	logic [31:0]       now_q;
	logic              any_q;
	logic [31:0]       best_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic  req_fire;
	logic  submit_wr;
	logic  tick_start;
	logic  live;
	logic  hit;
	logic  out_free;
	logic  stall;
	logic  issue;
	logic  report;
	eval_t ev;

	// input is blocked for the whole scan, so the memory never sees a write
	// to an entry that is in flight
	assign req_ready  = !scan_q;
	assign req_fire   = req_valid && req_ready;
	assign submit_wr  = req_fire && (req.op == OP_SUBMIT) &&
		(32'(req.channel) < 32'(CHANNELS));
	assign tick_start = req_fire && (req.op == OP_TICK);

	dtt_eval u_eval (
		.now      (now_q),
		.deadline (rd_s1.deadline),
		.result   (ev)
	);

	assign live     = v_s1 && pend_q[idx_s1];
	assign hit      = live && ev.fire;
	assign out_free = !out_valid_q || rsp_ready;
	assign stall    = hit && !out_free;
	assign issue    = scan_q && (idx_q < CNT_W'(CHANNELS)) && !stall;
	assign report   = scan_q && (idx_q == CNT_W'(CHANNELS)) && !v_s1 && out_free;

	// channel memory: one write port for submits, one registered read port
	always_ff @(posedge clk) begin
		if (submit_wr) begin
			mem_q[CH_W'(req.channel)] <= '{deadline: req.deadline, payload: req.payload};
		end
		if (issue) begin
			rd_s1 <= mem_q[CH_W'(idx_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			pend_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_start) begin
				scan_q <= 1'b1;
				idx_q  <= '0;
				any_q  <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (!stall) begin
				v_s1 <= issue;
			end
			if (report) begin
				scan_q <= 1'b0;
			end
			if (submit_wr) begin
				pend_q[CH_W'(req.channel)] <= 1'b1;
			end
			if (hit && out_free) begin
				pend_q[idx_s1] <= 1'b0;
			end
			if (live && !ev.fire) begin
				any_q <= 1'b1;
			end
			if ((hit && out_free) || report) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_start) begin
			now_q <= req.now;
		end
		if (issue) begin
			idx_s1 <= CH_W'(idx_q);
		end
		if (live && !ev.fire && (!any_q || (ev.remain < best_q))) begin
			best_q <= ev.remain;
		end
		if (hit && out_free) begin
			out_q <= '{kind: KIND_DONE, done_channel: 4'(idx_s1),
				reply: rd_s1.payload, wait_time: 32'sd0, last: 1'b0};
		end else if (report) begin
			out_q <= '{kind: KIND_REPORT, done_channel: 4'd0, reply: 32'd0,
				wait_time: any_q ? $signed(best_q) : WAIT_NONE, last: 1'b1};
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: design/dtt_checker.sv
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks for the deadline timer table, bound to the top level.
// ----------------------------------------------------------------------------
module dtt_checker import dtt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a held result item stays put until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// an accepted tick starts a scan that blocks input
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.op == OP_TICK) |=> !req_ready)
		else $error("tick did not start a scan");

	// a submit never blocks the input side
	a_submit_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.op == OP_SUBMIT) |=> req_ready)
		else $error("submit left the block busy");

	// only the report closes a tick, and a completion is only seen mid-scan
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind == KIND_REPORT)))
		else $error("last flag does not match result kind");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_DONE) |-> !req_ready)
		else $error("completion item outside a scan");

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (.*);
